// ===== design/mbgs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbgs_pkg
// Shared types and constants for the masked bilinear grid sampler.
// ----------------------------------------------------------------------------
package mbgs_pkg;

  localparam int unsigned RowBitsDef = 8;
  localparam int unsigned ColBitsDef = 8;

  localparam logic [23:0] CellSizeRst = 24'd256;
  localparam logic [8:0]  RowsRst     = 9'd256;
  localparam logic [8:0]  ColsRst     = 9'd256;

  localparam logic [1:0] RegCellSize = 2'd0;
  localparam logic [1:0] RegRows     = 2'd1;
  localparam logic [1:0] RegCols     = 2'd2;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // one query after the front end: cell indices and fractions
  typedef struct packed {
    logic signed [32:0] rn;
    logic signed [32:0] cn;
    logic [16:0]        fx;
    logic [16:0]        fz;
  } query_t;

  typedef enum logic [2:0] {
    FeIdle,
    FeDivX,
    FeDivZ,
    FeFracX,
    FeFracZ,
    FePush
  } fe_state_e;

  typedef enum logic [2:0] {
    BeIdle,
    BeRead,
    BeMul,
    BeAcc,
    BeDiv,
    BeOut
  } be_state_e;

endpackage

// ===== design/mbgs_if.sv =====
// ----------------------------------------------------------------------------
// mbgs channel interfaces
// Item, result and register-write channels of the grid sampler, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface mbgs_in_if;
  logic valid, ready, mode, cell_valid;
  logic [7:0] cell_row, cell_col;
  logic signed [31:0] cell_value, pos_x, pos_z;
  modport source (output valid, mode, cell_row, cell_col, cell_value, cell_valid,
                  pos_x, pos_z, input ready);
  modport sink   (input valid, mode, cell_row, cell_col, cell_value, cell_valid,
                  pos_x, pos_z, output ready);
endinterface

interface mbgs_out_if;
  logic valid, ready, no_valid_neighbour;
  logic signed [31:0] sampled_value;
  modport source (output valid, sampled_value, no_valid_neighbour, input ready);
  modport sink   (input valid, sampled_value, no_valid_neighbour, output ready);
endinterface

interface mbgs_cfg_if;
  logic valid, ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mbgs_front.sv =====
// ----------------------------------------------------------------------------
// mbgs_front
// Accepts queries, divides positions by the cell size (restoring, one bit
// per cycle) to get cell indices and Q0.16 fractions.
// ----------------------------------------------------------------------------
module mbgs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [23:0]            cell_size_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  logic signed [31:0]     pos_x_i,
  input  logic signed [31:0]     pos_z_i,
  output logic                   o_valid_o,
  input  logic                   o_ready_i,
  output mbgs_pkg::query_t       o_data_o
);

  mbgs_pkg::fe_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] num_q, num_d;      // shifting dividend (magnitude)
  logic [24:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [23:0] cs_q, cs_d;
  logic signed [31:0] pz_q, pz_d;
  logic [23:0] remx_q, remx_d, remz_q, remz_d;
  mbgs_pkg::query_t res_q, res_d;

  logic [24:0] trial;
  logic [24:0] shifted;
  logic [31:0] qmag;
  logic [24:0] rfix;
  logic        rnz;

  assign shifted  = {rem_q[23:0], num_q[32]};
  assign trial    = shifted - {1'b0, cs_q};
  assign qmag     = num_q[31:0];
  assign rnz      = (rem_q != 25'd0);
  assign rfix     = {1'b0, cs_q} - rem_q;
  assign q_ready_o = (state_q == mbgs_pkg::FeIdle);
  assign o_valid_o = (state_q == mbgs_pkg::FePush);
  assign o_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbgs_pkg::FeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    cs_q   <= cs_d;
    pz_q   <= pz_d;
    remx_q <= remx_d;
    remz_q <= remz_d;
    res_q  <= res_d;
  end

  always_comb begin
    logic signed [32:0] qs;
    logic [23:0]        rr;
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cs_d    = cs_q;
    pz_d    = pz_q;
    remx_d  = remx_q;
    remz_d  = remz_q;
    res_d   = res_q;
    qs      = '0;
    rr      = '0;
    case (state_q)
      mbgs_pkg::FeIdle: begin
        if (q_valid_i) begin
          cs_d  = (cell_size_i == 24'd0) ? 24'd1 : cell_size_i;
          pz_d  = pos_z_i;
          neg_d = pos_x_i[31];
          num_d = {1'b0, pos_x_i[31] ? 32'(-pos_x_i) : 32'(pos_x_i)};
          num_d = {num_d[31:0], 1'b0};
          rem_d = '0;
          cnt_d = 6'd32;
          state_d = mbgs_pkg::FeDivX;
        end
      end
      mbgs_pkg::FeDivX, mbgs_pkg::FeDivZ, mbgs_pkg::FeFracX, mbgs_pkg::FeFracZ: begin
        if (cnt_q != 6'd0) begin
          // num_q[32] is the next dividend bit, quotient bits fill num_q[31:0]
          if (!trial[24]) begin
            rem_d = trial;
            num_d = {num_q[31:0], 1'b1};
          end else begin
            rem_d = shifted;
            num_d = {num_q[31:0], 1'b0};
          end
          cnt_d = cnt_q - 6'd1;
        end else begin
          case (state_q)
            mbgs_pkg::FeDivX, mbgs_pkg::FeDivZ: begin
              // floor correction for negative dividends
              if (neg_q && rnz) begin
                qs = -$signed({1'b0, qmag}) - 33'sd1;
                rr = rfix[23:0];
              end else begin
                qs = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
                rr = rem_q[23:0];
              end
              if (state_q == mbgs_pkg::FeDivX) begin
                res_d.cn = qs;
                remx_d   = rr;
                neg_d    = pz_q[31];
                num_d    = {1'b0, pz_q[31] ? 32'(-pz_q) : 32'(pz_q)};
                num_d    = {num_d[31:0], 1'b0};
                state_d  = mbgs_pkg::FeDivZ;
              end else begin
                res_d.rn = qs;
                remz_d   = rr;
                neg_d    = 1'b0;
                num_d    = {1'b0, remx_q[15:0], 16'd0};
                num_d    = {num_d[31:0], 1'b0};
                state_d  = mbgs_pkg::FeFracX;
              end
              rem_d = (state_q == mbgs_pkg::FeDivX) ? 25'd0 : {17'd0, remx_q[23:16]};
              cnt_d = 6'd32;
            end
            mbgs_pkg::FeFracX: begin
              res_d.fx = qmag[16:0];
              num_d    = {1'b0, remz_q[15:0], 16'd0};
              num_d    = {num_d[31:0], 1'b0};
              rem_d    = {17'd0, remz_q[23:16]};
              cnt_d    = 6'd32;
              state_d  = mbgs_pkg::FeFracZ;
            end
            default: begin
              res_d.fz = qmag[16:0];
              state_d  = mbgs_pkg::FePush;
            end
          endcase
        end
      end
      mbgs_pkg::FePush: begin
        if (o_ready_i) state_d = mbgs_pkg::FeIdle;
      end
      default: state_d = mbgs_pkg::FeIdle;
    endcase
  end

endmodule

// ===== design/mbgs_back.sv =====
// ----------------------------------------------------------------------------
// mbgs_back
// Grid memories, cell writes, four neighbour reads, weighted sum and a
// bit-serial signed rounding divide.
// ----------------------------------------------------------------------------
module mbgs_back #(
  parameter int unsigned ROW_BITS = mbgs_pkg::RowBitsDef,
  parameter int unsigned COL_BITS = mbgs_pkg::ColBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [8:0]             rows_i,
  input  logic [8:0]             cols_i,
  output logic                   busy_o,
  input  logic                   wr_valid_i,
  output logic                   wr_ready_o,
  input  logic [7:0]             wr_row_i,
  input  logic [7:0]             wr_col_i,
  input  logic signed [31:0]     wr_value_i,
  input  logic                   wr_cell_valid_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  mbgs_pkg::query_t       q_data_i,
  output logic                   r_valid_o,
  input  logic                   r_ready_i,
  output logic signed [31:0]     r_value_o,
  output logic                   r_none_o
);

  localparam int unsigned AW    = ROW_BITS + COL_BITS;
  localparam int unsigned Cells = 1 << AW;

  logic [31:0] elev_mem [Cells];
  logic        vld_mem  [Cells];
  logic [AW:0] clr_q;             // clearing pass pointer
  logic        clearing;

  mbgs_pkg::be_state_e state_q, state_d;
  mbgs_pkg::query_t    qry_q, qry_d;
  logic [1:0]  nb_q, nb_d;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_elev_q;
  logic        rd_vld_q;
  logic        keep_q, keep_d;
  logic [33:0] w_q, w_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [67:0] sum_q, sum_d;
  logic [35:0] wsum_q, wsum_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [67:0] mag_q, mag_d;
  logic [36:0] rem_q, rem_d;
  logic        sneg_q, sneg_d;
  logic signed [31:0] res_q, res_d;
  logic        none_q, none_d;

  assign clearing = !clr_q[AW];
  assign busy_o   = (state_q != mbgs_pkg::BeIdle) || clearing;
  assign wr_ready_o = !clearing && (state_q == mbgs_pkg::BeIdle);
  assign q_ready_o  = !clearing && (state_q == mbgs_pkg::BeIdle) && !wr_valid_i;
  assign r_valid_o  = (state_q == mbgs_pkg::BeOut);
  assign r_value_o  = res_q;
  assign r_none_o   = none_q;

  // neighbour address and bounds
  logic signed [32:0] nr, nc;
  logic [12:0] lim_r, lim_c;
  logic        inb;
  logic [16:0] wa, wb;
  always_comb begin
    nr = nb_q[0] ? qry_q.rn - 33'sd1 : qry_q.rn;
    nc = nb_q[1] ? qry_q.cn - 33'sd1 : qry_q.cn;
    lim_r = ({4'd0, rows_i} > 13'(1 << ROW_BITS)) ? 13'(1 << ROW_BITS) : {4'd0, rows_i};
    lim_c = ({4'd0, cols_i} > 13'(1 << COL_BITS)) ? 13'(1 << COL_BITS) : {4'd0, cols_i};
    inb = !nr[32] && !nc[32] && (nr < $signed({20'd0, lim_r}))
          && (nc < $signed({20'd0, lim_c}));
    rd_addr = {nr[ROW_BITS-1:0], nc[COL_BITS-1:0]};
    wa = nb_q[1] ? 17'(17'd65536 - qry_q.fx) : qry_q.fx;
    wb = nb_q[0] ? 17'(17'd65536 - qry_q.fz) : qry_q.fz;
  end
  assign rd_en = (state_q == mbgs_pkg::BeRead);

  logic wr_fire, wr_fit;
  logic [AW-1:0] wr_idx;
  assign wr_fire = wr_valid_i && wr_ready_o;
  assign wr_fit  = ({8'd0, wr_row_i} < 16'(1 << ROW_BITS))
                && ({8'd0, wr_col_i} < 16'(1 << COL_BITS));
  assign wr_idx  = {ROW_BITS'(wr_row_i), COL_BITS'(wr_col_i)};

  always_ff @(posedge clk_i) begin
    if (wr_fire && wr_fit)
      elev_mem[wr_idx] <= wr_value_i;
    if (rd_en) rd_elev_q <= elev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (clearing)
      vld_mem[clr_q[AW-1:0]] <= 1'b0;
    else if (wr_fire && wr_fit)
      vld_mem[wr_idx] <= wr_cell_valid_i;
    if (rd_en) rd_vld_q <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      state_q <= mbgs_pkg::BeIdle;
      nb_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      state_q <= state_d;
      nb_q    <= nb_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q  <= qry_d;
    keep_q <= keep_d;
    w_q    <= w_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    wsum_q <= wsum_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    sneg_q <= sneg_d;
    res_q  <= res_d;
    none_q <= none_d;
  end

  always_comb begin
    logic [37:0] trial;
    logic [37:0] sh;
    logic [31:0] qm;
    logic [37:0] twice;
    state_d = state_q;
    nb_d    = nb_q;
    cnt_d   = cnt_q;
    qry_d   = qry_q;
    keep_d  = keep_q;
    w_d     = w_q;
    prod_d  = prod_q;
    sum_d   = sum_q;
    wsum_d  = wsum_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    sneg_d  = sneg_q;
    res_d   = res_q;
    none_d  = none_q;
    sh      = {rem_q, mag_q[67]};
    trial   = sh - {2'b0, wsum_q};
    qm      = mag_q[31:0];
    twice   = {rem_q, 1'b0};
    case (state_q)
      mbgs_pkg::BeIdle: begin
        if (q_valid_i && q_ready_o) begin
          qry_d  = q_data_i;
          nb_d   = '0;
          sum_d  = '0;
          wsum_d = '0;
          state_d = mbgs_pkg::BeRead;
        end
      end
      mbgs_pkg::BeRead: begin
        keep_d  = inb;
        w_d     = 34'(wa) * 34'(wb);
        state_d = mbgs_pkg::BeMul;
      end
      mbgs_pkg::BeMul: begin
        keep_d  = keep_q && rd_vld_q;
        prod_d  = $signed({1'b0, w_q[32:0]}) * $signed(rd_elev_q);
        state_d = mbgs_pkg::BeAcc;
      end
      mbgs_pkg::BeAcc: begin
        if (keep_q) begin
          sum_d  = sum_q + 68'(prod_q);
          wsum_d = wsum_q + 36'(w_q);
        end
        nb_d = nb_q + 2'd1;
        if (nb_q == 2'd3) begin
          sneg_d = sum_d[67];
          mag_d  = sum_d[67] ? 68'(-sum_d) : 68'(sum_d);
          rem_d  = '0;
          cnt_d  = 7'd68;
          state_d = mbgs_pkg::BeDiv;
        end else begin
          state_d = mbgs_pkg::BeRead;
        end
      end
      mbgs_pkg::BeDiv: begin
        if (wsum_q == 36'd0) begin
          res_d  = '0;
          none_d = 1'b1;
          state_d = mbgs_pkg::BeOut;
        end else if (cnt_q != 7'd0) begin
          if (!trial[37]) begin
            rem_d = trial[36:0];
            mag_d = {mag_q[66:0], 1'b1};
          end else begin
            rem_d = sh[36:0];
            mag_d = {mag_q[66:0], 1'b0};
          end
          cnt_d = cnt_q - 7'd1;
        end else begin
          // round half away from zero on the magnitude
          if (twice >= {2'b0, wsum_q}) qm = qm + 32'd1;
          res_d  = sneg_q ? 32'(-qm) : qm;
          none_d = 1'b0;
          state_d = mbgs_pkg::BeOut;
        end
      end
      mbgs_pkg::BeOut: begin
        if (r_ready_i) state_d = mbgs_pkg::BeIdle;
      end
      default: state_d = mbgs_pkg::BeIdle;
    endcase
  end

endmodule

// ===== design/mbgs_queue.sv =====
// ----------------------------------------------------------------------------
// mbgs_queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module mbgs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mbgs_pkg::query_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mbgs_pkg::query_t out_data_o
);
  mbgs_pkg::query_t mem_q [2];
  logic [1:0] cnt_q;
  logic       rp_q, wp_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rp_q  <= 1'b0;
      wp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/masked_bilinear_grid_sampler_core.sv =====
// ----------------------------------------------------------------------------
// masked_bilinear_grid_sampler_core
// Bilinear sampling over a masked elevation grid.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_if     in   mode, cell_row, cell_col, cell_value, cell_valid, pos_x, pos_z
// out_if    out  sampled_value, no_valid_neighbour (one per query)
// cfg_if    in   index (0 cell_size, 1 rows_in_use, 2 cols_in_use), data
//
// A query passes the front through four 32-step restoring divides and a
// hand-off, and the back through four single-port neighbour reads, a
// 68-step rounding divide and the output; with no weight kept the back
// skips the divide. Writes wait until earlier queries have left the front
// end, the queue and the back end. After reset a clearing pass over all
// 2^(ROW_BITS+COL_BITS) cells wipes the valid store; writes are held then
// and queries wait in the queue.
// ----------------------------------------------------------------------------
module masked_bilinear_grid_sampler_core #(
  parameter int unsigned ROW_BITS = mbgs_pkg::RowBitsDef,
  parameter int unsigned COL_BITS = mbgs_pkg::ColBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbgs_in_if.sink      in_if,
  mbgs_out_if.source   out_if,
  mbgs_cfg_if.sink     cfg_if
);
  logic [23:0] cell_size_q;
  logic [8:0]  rows_q, cols_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= mbgs_pkg::CellSizeRst;
      rows_q      <= mbgs_pkg::RowsRst;
      cols_q      <= mbgs_pkg::ColsRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        mbgs_pkg::RegCellSize: cell_size_q <= cfg_if.data[23:0];
        mbgs_pkg::RegRows:     rows_q      <= cfg_if.data[8:0];
        mbgs_pkg::RegCols:     cols_q      <= cfg_if.data[8:0];
        default: ;
      endcase
    end
  end

  logic is_wr, fe_ready, fe_valid, qq_ready, qq_valid, be_q_ready;
  logic be_busy, be_wr_ready, pend_q, wr_ok;
  mbgs_pkg::query_t fe_data, qq_data;

  assign is_wr = (in_if.mode == mbgs_pkg::ModeWrite);
  // writes must not overtake queries still in flight
  assign wr_ok = !pend_q && !qq_valid && fe_ready;
  assign in_if.ready = is_wr ? (be_wr_ready && wr_ok) : fe_ready;

  // tracks a query in the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else pend_q <= be_busy;
  end

  mbgs_front u_front (
    .clk_i, .rst_ni,
    .cell_size_i (cell_size_q),
    .q_valid_i   (in_if.valid && !is_wr),
    .q_ready_o   (fe_ready),
    .pos_x_i     (in_if.pos_x),
    .pos_z_i     (in_if.pos_z),
    .o_valid_o   (fe_valid),
    .o_ready_i   (qq_ready),
    .o_data_o    (fe_data)
  );

  mbgs_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (fe_valid),
    .in_ready_o  (qq_ready),
    .in_data_i   (fe_data),
    .out_valid_o (qq_valid),
    .out_ready_i (be_q_ready),
    .out_data_o  (qq_data)
  );

  mbgs_back #(.ROW_BITS(ROW_BITS), .COL_BITS(COL_BITS)) u_back (
    .clk_i, .rst_ni,
    .rows_i          (rows_q),
    .cols_i          (cols_q),
    .busy_o          (be_busy),
    .wr_valid_i      (in_if.valid && is_wr && wr_ok),
    .wr_ready_o      (be_wr_ready),
    .wr_row_i        (in_if.cell_row),
    .wr_col_i        (in_if.cell_col),
    .wr_value_i      (in_if.cell_value),
    .wr_cell_valid_i (in_if.cell_valid),
    .q_valid_i       (qq_valid),
    .q_ready_o       (be_q_ready),
    .q_data_i        (qq_data),
    .r_valid_o       (out_if.valid),
    .r_ready_i       (out_if.ready),
    .r_value_o       (out_if.sampled_value),
    .r_none_o        (out_if.no_valid_neighbour)
  );
endmodule

// ===== tb/mbgs_chan_if.sv =====
// ----------------------------------------------------------------------------
// mbgs_chan_pkg
// Item and result records used by the testbench to hold stimulus and
// expected samples.
// ----------------------------------------------------------------------------
package mbgs_chan_pkg;

  typedef struct packed {
    logic               mode;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic signed [31:0] cell_value;
    logic               cell_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sampled_value;
    logic               no_valid_neighbour;
  } sample_t;

endpackage

// ===== tb/masked_bilinear_grid_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// masked_bilinear_grid_sampler_core_tb
// Writes grid cells and fires queries through phases of cell size and map
// extent; every sample is compared with a typed or locally predicted value.
// ----------------------------------------------------------------------------
module masked_bilinear_grid_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  GridCells  = 1 << (mbgs_pkg::RowBitsDef + mbgs_pkg::ColBitsDef);
  localparam int  SettleCyc  = 400;
  localparam longint CycLimit = 3_000_000;

  typedef struct {
    mbgs_chan_pkg::item_t   item;
    bit                     typed;
    mbgs_chan_pkg::sample_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mbgs_in_if  in_if ();
  mbgs_out_if out_if ();
  mbgs_cfg_if cfg_if ();

  masked_bilinear_grid_sampler_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // grid mirror and register copies
  logic [31:0] elev_mirror [GridCells];
  bit          valid_mirror [GridCells];
  longint      cell_size_q = mbgs_pkg::CellSizeRst;
  longint      rows_q = mbgs_pkg::RowsRst;
  longint      cols_q = mbgs_pkg::ColsRst;

  mbgs_chan_pkg::sample_t pending_samples [$];
  int      n_errors = 0;
  int      n_samples = 0;
  int      n_writes = 0;
  int      n_flagged = 0;
  bit      calm = 1'b0;
  longint  cyc = 0;

  function automatic void add_cell(longint r, longint c, longint lr, longint lc, longint w,
                                   inout longint acc, inout longint wacc);
    int idx;
    if (r < 0 || r >= lr || c < 0 || c >= lc) return;
    idx = int'((r << mbgs_pkg::ColBitsDef) | c);
    if (!valid_mirror[idx]) return;
    acc  += w * longint'($signed(elev_mirror[idx]));
    wacc += w;
  endfunction

  function automatic mbgs_chan_pkg::sample_t bilinear_sample(logic signed [31:0] px,
                                                             logic signed [31:0] pz);
    mbgs_chan_pkg::sample_t s;
    longint cs, x, z, cn, rn, rx, rz, fx, fz, gx, gz, lr, lc, acc, wacc, q, r;
    cs = (cell_size_q == 0) ? 1 : cell_size_q;
    x = px;
    z = pz;
    cn = x / cs;  rx = x % cs;
    if (rx < 0) begin cn -= 1; rx += cs; end
    rn = z / cs;  rz = z % cs;
    if (rz < 0) begin rn -= 1; rz += cs; end
    fx = (rx * 65536) / cs;
    fz = (rz * 65536) / cs;
    gx = 65536 - fx;
    gz = 65536 - fz;
    lr = (rows_q > (1 << mbgs_pkg::RowBitsDef)) ? (1 << mbgs_pkg::RowBitsDef) : rows_q;
    lc = (cols_q > (1 << mbgs_pkg::ColBitsDef)) ? (1 << mbgs_pkg::ColBitsDef) : cols_q;
    acc = 0;
    wacc = 0;
    add_cell(rn, cn, lr, lc, fx * fz, acc, wacc);
    add_cell(rn - 1, cn, lr, lc, fx * gz, acc, wacc);
    add_cell(rn, cn - 1, lr, lc, gx * fz, acc, wacc);
    add_cell(rn - 1, cn - 1, lr, lc, gx * gz, acc, wacc);
    if (wacc <= 0) begin
      s.sampled_value = '0;
      s.no_valid_neighbour = 1'b1;
      return s;
    end
    q = acc / wacc;
    r = acc % wacc;
    if (r < 0) r = -r;
    // round half away from zero
    if (2 * r >= wacc) q += (acc < 0) ? -1 : 1;
    s.sampled_value = q[31:0];
    s.no_valid_neighbour = 1'b0;
    return s;
  endfunction

  // applied at the accepting edge
  task automatic note_accepted(stim_row_t st);
    if (st.item.mode == mbgs_pkg::ModeWrite) begin
      n_writes++;
      valid_mirror[{st.item.cell_row, st.item.cell_col}] = st.item.cell_valid;
      elev_mirror[{st.item.cell_row, st.item.cell_col}] = st.item.cell_value;
    end else begin
      pending_samples.push_back(st.typed ? st.want
                                         : bilinear_sample(st.item.pos_x, st.item.pos_z));
    end
  endtask

  task automatic send_item(stim_row_t st);
    while (!calm && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= st.item.mode;
    in_if.cell_row   <= st.item.cell_row;
    in_if.cell_col   <= st.item.cell_col;
    in_if.cell_value <= st.item.cell_value;
    in_if.cell_valid <= st.item.cell_valid;
    in_if.pos_x      <= st.item.pos_x;
    in_if.pos_z      <= st.item.pos_z;
    do @(posedge clk_i); while (!in_if.ready);
    note_accepted(st);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= {8'd0, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      mbgs_pkg::RegCellSize: cell_size_q = val;
      mbgs_pkg::RegRows:     rows_q = val[8:0];
      mbgs_pkg::RegCols:     cols_q = val[8:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  function automatic mbgs_chan_pkg::item_t cell_write(int r, int c, logic [31:0] v, bit ok);
    mbgs_chan_pkg::item_t it;
    it = '0;
    it.mode = mbgs_pkg::ModeWrite;
    it.cell_row = r[7:0];
    it.cell_col = c[7:0];
    it.cell_value = v;
    it.cell_valid = ok;
    return it;
  endfunction

  function automatic mbgs_chan_pkg::item_t query_at(logic [31:0] x, logic [31:0] z);
    mbgs_chan_pkg::item_t it;
    it = '0;
    it.mode = mbgs_pkg::ModeQuery;
    it.pos_x = x;
    it.pos_z = z;
    return it;
  endfunction

  function automatic logic [31:0] rand_pos(longint cs, longint span);
    longint p;
    if ($urandom_range(99) < 15) return $urandom;
    p = cs * longint'($urandom_range(0, int'(span + 1))) - cs / 2
        + longint'($urandom_range(0, int'(cs - 1)));
    return p[31:0];
  endfunction

  task automatic random_phase(logic [23:0] cs, logic [8:0] rows, logic [8:0] cols, int n);
    stim_row_t st;
    longint    cse;
    int        rh, ch;
    write_reg(mbgs_pkg::RegCellSize, cs);
    write_reg(mbgs_pkg::RegRows, {15'd0, rows});
    write_reg(mbgs_pkg::RegCols, {15'd0, cols});
    cfg_if.valid <= 1'b0;
    cse = (cs == 0) ? 1 : cs;
    rh = (rows > 10) ? 10 : rows;
    ch = (cols > 10) ? 10 : cols;
    for (int i = 0; i < n; i++) begin
      st.typed = 1'b0;
      st.want = '0;
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) == 0)
          st.item = cell_write($urandom_range(255), $urandom_range(255), $urandom,
                               $urandom_range(1));
        else
          st.item = cell_write($urandom_range(rh), $urandom_range(ch), $urandom,
                               $urandom_range(99) < 80);
        // scatter noise on the query fields, ignored in write mode
        st.item.pos_x = $urandom;
        st.item.pos_z = $urandom;
      end else begin
        st.item = query_at(rand_pos(cse, ch), rand_pos(cse, rh));
        st.item.cell_row = 8'($urandom_range(255));
        st.item.cell_col = 8'($urandom_range(255));
        st.item.cell_value = $urandom;
        st.item.cell_valid = 1'($urandom_range(1));
      end
      send_item(st);
    end
    settle();
  endtask

  // result side
  always @(posedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    if (out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        $error("sample with none outstanding: value %0d flag %0b",
               out_if.sampled_value, out_if.no_valid_neighbour);
        n_errors++;
      end else begin
        mbgs_chan_pkg::sample_t w;
        w = pending_samples.pop_front();
        n_samples++;
        if (w.no_valid_neighbour) n_flagged++;
        if (out_if.sampled_value !== w.sampled_value) begin
          $error("sampled_value expected %0d actual %0d", w.sampled_value,
                 out_if.sampled_value);
          n_errors++;
        end
        if (out_if.no_valid_neighbour !== w.no_valid_neighbour) begin
          $error("no_valid_neighbour expected %0b actual %0b", w.no_valid_neighbour,
                 out_if.no_valid_neighbour);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t directed [$];
    in_if.valid = 1'b0;
    in_if.mode = mbgs_pkg::ModeWrite;
    in_if.cell_row = '0;
    in_if.cell_col = '0;
    in_if.cell_value = '0;
    in_if.cell_valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = mbgs_pkg::RegCellSize;
    cfg_if.data = '0;
    foreach (valid_mirror[i]) begin
      valid_mirror[i] = 1'b0;
      elev_mirror[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty grid after reset
    directed.push_back('{query_at(32'sd300, 32'sd300), 1'b1, '{32'sd0, 1'b1}});
    directed.push_back('{cell_write(0, 0, 32'sd1000, 1'b1), 1'b0, '0});
    // on the cell corner the only non-zero weight falls outside the map
    directed.push_back('{query_at(32'sd0, 32'sd0), 1'b1, '{32'sd0, 1'b1}});
    directed.push_back('{query_at(32'sd256, 32'sd256), 1'b1, '{32'sd1000, 1'b0}});
    directed.push_back('{cell_write(0, 1, 32'sd3000, 1'b1), 1'b0, '0});
    directed.push_back('{cell_write(1, 0, -32'sd500, 1'b1), 1'b0, '0});
    directed.push_back('{cell_write(1, 1, 32'sd7, 1'b1), 1'b0, '0});
    directed.push_back('{query_at(32'sd384, 32'sd384), 1'b0, '0});
    directed.push_back('{query_at(32'sd300, 32'sd450), 1'b0, '0});
    directed.push_back('{cell_write(255, 255, 32'h8000_0000, 1'b1), 1'b0, '0});
    directed.push_back('{query_at(32'sd65536, 32'sd65536), 1'b1,
                         '{32'sh8000_0000, 1'b0}});
    directed.push_back('{cell_write(255, 254, 32'h7fff_ffff, 1'b1), 1'b0, '0});
    directed.push_back('{query_at(32'sd65280, 32'sd65536), 1'b1,
                         '{32'sh7fff_ffff, 1'b0}});
    directed.push_back('{query_at(32'sd65400, 32'sd65536), 1'b0, '0});
    // missing-value mark drops the cell
    directed.push_back('{cell_write(0, 0, 32'sd1000, 1'b0), 1'b0, '0});
    directed.push_back('{query_at(32'sd256, 32'sd256), 1'b1, '{32'sd0, 1'b1}});
    directed.push_back('{query_at(32'sh7fff_ffff, 32'sh7fff_ffff), 1'b1, '{32'sd0, 1'b1}});
    directed.push_back('{query_at(32'sh8000_0000, 32'sh8000_0000), 1'b1, '{32'sd0, 1'b1}});
    directed.push_back('{query_at(-32'sd1, 32'sd200), 1'b0, '0});
    directed.push_back('{cell_write(255, 255, 32'hffff_ffff, 1'b1), 1'b0, '0});
    directed.push_back('{query_at(32'sd65500, 32'sd65300), 1'b0, '0});
    foreach (directed[i]) send_item(directed[i]);
    settle();

    random_phase(24'd256, 9'd256, 9'd256, 70);
    random_phase(24'd1000, 9'd8, 9'd8, 70);
    calm = 1'b1;
    random_phase(24'd0, 9'd4, 9'd300, 70);
    calm = 1'b0;
    random_phase(24'd16777215, 9'd256, 9'd1, 60);
    random_phase(24'd1, 9'd511, 9'd511, 60);
    random_phase(24'd77, 9'd6, 9'd9, 70);
    random_phase(24'd600, 9'd0, 9'd0, 30);
    random_phase(24'd513, 9'd12, 9'd3, 60);

    $display("covered %0d cell writes and %0d samples (%0d with no neighbour kept)",
             n_writes, n_samples, n_flagged);
    $display("over eight register settings including size zero and full-scale extremes");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
